// File: hdl/chip8_instruction_execute_top_defines.svh
// Assertion macros used by the checker file of the instruction execute block.
`ifndef CHIP8_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define C8X_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define C8X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Types, codes and helpers shared by the instruction execute block.
// ----------------------------------------------------------------------------
package c8x_pkg;

  // Default geometry
  localparam int RamDepthDef    = 4096;
  localparam int StackDepthDef  = 16;
  localparam int ScreenHeightDef = 32;
  localparam int SCREEN_WIDTH   = 64;
  localparam int PROGRAM_START  = 512;
  localparam int FONT_BASE      = 0;

  // Request kinds
  localparam logic [1:0] KIND_EXEC = 2'd0;
  localparam logic [1:0] KIND_MEM  = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BAD_OP = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_MEM    = 3'd4;
  localparam logic [2:0] ST_KEY    = 3'd5;

  // Timer selects
  localparam logic [1:0] TW_NONE  = 2'd0;
  localparam logic [1:0] TW_DELAY = 2'd1;
  localparam logic [1:0] TW_SOUND = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHIFT_VX = 2'd0;
  localparam logic [1:0] CFG_KEEP_IDX = 2'd1;
  localparam logic [1:0] CFG_WAIT_REL = 2'd2;

  // Opcode top nibbles
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // System and misc sub-codes
  localparam logic [11:0] SYS_CLS  = 12'h0E0;
  localparam logic [11:0] SYS_RET  = 12'h0EE;
  localparam logic [7:0]  KK_SKP   = 8'h9E;
  localparam logic [7:0]  KK_SKNP  = 8'hA1;
  localparam logic [7:0]  KK_LDDT  = 8'h07;
  localparam logic [7:0]  KK_WAIT  = 8'h0A;
  localparam logic [7:0]  KK_SETDT = 8'h15;
  localparam logic [7:0]  KK_SETST = 8'h18;
  localparam logic [7:0]  KK_ADDI  = 8'h1E;
  localparam logic [7:0]  KK_FONT  = 8'h29;
  localparam logic [7:0]  KK_BCD   = 8'h33;
  localparam logic [7:0]  KK_STORE = 8'h55;
  localparam logic [7:0]  KK_LOAD  = 8'h65;

  // ALU selectors
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Instruction classes that need follow-up sequencing
  typedef enum logic [2:0] {
    CL_SIMPLE, CL_FLAG, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD
  } cls_e;

  // Datapath commands, one per controller step
  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_RDX, CMD_RDY, CMD_EXEC, CMD_FLAG, CMD_DMOD,
    CMD_DRD, CMD_DWR, CMD_DVF, CMD_BCD, CMD_BST, CMD_BLDR, CMD_BLDW,
    CMD_MEMWR, CMD_ROWRD, CMD_ROWCAP, CMD_RESULT
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] opcode;
    logic [7:0]  random_byte;
    logic [15:0] keys_held;
    logic [7:0]  delay_value;
    logic [11:0] address;
    logic [7:0]  data;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic [1:0]  timer_write;
    logic [7:0]  timer_value;
    logic [63:0] display_row;
    logic        waiting_key;
  } out_rsp_t;

  typedef struct packed {
    cmd_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fault;
    cls_e       cls;
    logic       cnt_last;
    logic       row_ok;
    logic       draw_empty;
  } sts_t;

  // One decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [7:0]  hund;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [7:0]  tens;
    logic [7:0]  ones;
    hund = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
    rem  = v - 8'(hund * 8'd100);
    prod = 16'(rem) * 16'd205;
    tens = 8'(prod >> 11);
    ones = rem - 8'(tens * 8'd10);
    unique case (sel)
      2'd0:    bcd_digit = hund;
      2'd1:    bcd_digit = tens;
      default: bcd_digit = ones;
    endcase
  endfunction

endpackage

// File: hdl/chip8_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// CHIP-8 instruction execute unit: one request in, one result out.
//
//   channel | signals                          | payload
//   in      | in_valid_i / in_ready_o          | in_req_i   (c8x_pkg::in_req_t)
//   out     | out_valid_o / out_ready_i        | out_rsp_o  (c8x_pkg::out_rsp_t)
//   cfg     | cfg_valid_i / cfg_ready_o        | cfg_index_i, cfg_data_i
//
// One request at a time. Plain instructions read Vx and Vy, then execute; ALU ops
// with a flag then write VF. A sprite draw wraps its start row into the screen,
// then reads and writes each row in turn through the single main-memory read port.
// Block store and BCD write memory step by step, block load reads then writes each.
// The next request is taken while a finished result waits at the output.
// Reset clears registers and the display through per-row valid bits; main memory
// and the return stack hold no reset value.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top #(
  parameter int RAM_DEPTH     = c8x_pkg::RamDepthDef,
  parameter int STACK_DEPTH   = c8x_pkg::StackDepthDef,
  parameter int SCREEN_HEIGHT = c8x_pkg::ScreenHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c8x_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output c8x_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic              cfg_data_i
);
  import c8x_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration writes land at once
  assign cfg_ready_o = 1'b1;

  c8x_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  c8x_dp #(
    .RAM_DEPTH     (RAM_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: hdl/c8x_ctrl.sv
// ----------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: accepts requests, steps the datapath, hands off results.
// ----------------------------------------------------------------------------
module c8x_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output c8x_pkg::cmd_t cmd_o,
  input  c8x_pkg::sts_t sts_i
);
  import c8x_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_RDX    = 5'd2;
  localparam logic [4:0] S_RDY    = 5'd3;
  localparam logic [4:0] S_EXEC   = 5'd4;
  localparam logic [4:0] S_FLAG   = 5'd5;
  localparam logic [4:0] S_DMOD   = 5'd6;
  localparam logic [4:0] S_DRD    = 5'd7;
  localparam logic [4:0] S_DWR    = 5'd8;
  localparam logic [4:0] S_DVF    = 5'd9;
  localparam logic [4:0] S_BCD    = 5'd10;
  localparam logic [4:0] S_BST    = 5'd11;
  localparam logic [4:0] S_BLDR   = 5'd12;
  localparam logic [4:0] S_BLDW   = 5'd13;
  localparam logic [4:0] S_MEMWR  = 5'd14;
  localparam logic [4:0] S_ROWRD  = 5'd15;
  localparam logic [4:0] S_ROWCAP = 5'd16;
  localparam logic [4:0] S_RESULT = 5'd17;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       res_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_load    = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  // Next state and command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.kind)
          KIND_EXEC: state_d = S_RDX;
          KIND_MEM:  state_d = S_MEMWR;
          KIND_ROW:  state_d = S_ROWRD;
          default:   state_d = S_RESULT;
        endcase
      end
      S_RDX: begin
        cmd_o.op = CMD_RDX;
        state_d  = S_RDY;
      end
      S_RDY: begin
        cmd_o.op = CMD_RDY;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = CMD_EXEC;
        if (sts_i.fault) begin
          state_d = S_RESULT;
        end else begin
          unique case (sts_i.cls)
            CL_FLAG:  state_d = S_FLAG;
            CL_DRAW:  state_d = S_DMOD;
            CL_BCD:   state_d = S_BCD;
            CL_STORE: state_d = S_BST;
            CL_LOAD:  state_d = S_BLDR;
            default:  state_d = S_RESULT;
          endcase
        end
      end
      S_FLAG: begin
        cmd_o.op = CMD_FLAG;
        state_d  = S_RESULT;
      end
      S_DMOD: begin
        cmd_o.op = CMD_DMOD;
        if (sts_i.row_ok) state_d = sts_i.draw_empty ? S_DVF : S_DRD;
      end
      S_DRD: begin
        cmd_o.op = CMD_DRD;
        state_d  = S_DWR;
      end
      S_DWR: begin
        cmd_o.op = CMD_DWR;
        state_d  = sts_i.cnt_last ? S_DVF : S_DRD;
      end
      S_DVF: begin
        cmd_o.op = CMD_DVF;
        state_d  = S_RESULT;
      end
      S_BCD: begin
        cmd_o.op = CMD_BCD;
        if (sts_i.cnt_last) state_d = S_RESULT;
      end
      S_BST: begin
        cmd_o.op = CMD_BST;
        if (sts_i.cnt_last) state_d = S_RESULT;
      end
      S_BLDR: begin
        cmd_o.op = CMD_BLDR;
        state_d  = S_BLDW;
      end
      S_BLDW: begin
        cmd_o.op = CMD_BLDW;
        state_d  = sts_i.cnt_last ? S_RESULT : S_BLDR;
      end
      S_MEMWR: begin
        cmd_o.op = CMD_MEMWR;
        state_d  = S_RESULT;
      end
      S_ROWRD: begin
        cmd_o.op = CMD_ROWRD;
        state_d  = S_ROWCAP;
      end
      S_ROWCAP: begin
        cmd_o.op = CMD_ROWCAP;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (res_load) begin
          cmd_o.op = CMD_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold a result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/c8x_dp.sv
// ----------------------------------------------------------------------------
// c8x_dp
// Datapath: registers, stack, main memory, display, decode and result register.
// ----------------------------------------------------------------------------
module c8x_dp #(
  parameter int RAM_DEPTH     = c8x_pkg::RamDepthDef,
  parameter int STACK_DEPTH   = c8x_pkg::StackDepthDef,
  parameter int SCREEN_HEIGHT = c8x_pkg::ScreenHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c8x_pkg::in_req_t  in_req_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic              cfg_data_i,
  input  c8x_pkg::cmd_t     cmd_i,
  output c8x_pkg::sts_t     sts_o,
  output c8x_pkg::out_rsp_t out_rsp_o
);
  import c8x_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int HW = $clog2(SCREEN_HEIGHT);
  localparam logic [16:0]   RamLim  = 17'(RAM_DEPTH);
  localparam logic [7:0]    ScrH    = 8'(SCREEN_HEIGHT);
  localparam logic [11:0]   ScrHA   = 12'(SCREEN_HEIGHT);
  localparam logic [PW-1:0] StkFull = PW'(STACK_DEPTH);
  localparam logic [15:0]   ProgSt  = 16'(PROGRAM_START);
  localparam logic [15:0]   FontB   = 16'(FONT_BASE);

  // Architectural state
  logic [7:0]    gp_q [16];
  logic [15:0]   pc_q, idx_q;
  logic [PW-1:0] sp_q;
  logic [SCREEN_HEIGHT-1:0] disp_vld_q;
  logic          cfg_shift_q, cfg_keep_q, cfg_wait_q;
  logic [7:0]    mem_q [RAM_DEPTH];
  logic [63:0]   disp_mem [SCREEN_HEIGHT];
  logic [15:0]   stk_mem [STACK_DEPTH];

  // Work registers
  in_req_t     in_q;
  logic [7:0]  vx_q, vy_q;
  logic [15:0] stk_rd_q;
  logic [7:0]  mem_rd_q;
  logic [63:0] disp_rd_q;
  logic        disp_vld_rd_q;
  logic        flag_q, coll_q, row_ok_q;
  cls_e        cls_q;
  logic [3:0]  cnt_q;
  logic [7:0]  drow_q;
  logic [2:0]  st_q;
  logic [1:0]  tw_q;
  logic [7:0]  tv_q;
  logic        wk_q;
  logic [63:0] row_q;
  out_rsp_t    out_q;

  // Field split
  logic [3:0]  op_hi, x, y, z;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign op_hi = in_q.opcode[15:12];
  assign x     = in_q.opcode[11:8];
  assign y     = in_q.opcode[7:4];
  assign z     = in_q.opcode[3:0];
  assign kk    = in_q.opcode[7:0];
  assign nnn   = in_q.opcode[11:0];

  logic [16:0]   idx_ext, blk_addr, draw_end, blk_end, bcd_end;
  logic [PW-1:0] spm1;
  assign idx_ext  = {1'b0, idx_q};
  assign blk_addr = idx_ext + 17'(cnt_q);
  assign draw_end = idx_ext + 17'(z) - 17'd1;
  assign blk_end  = idx_ext + 17'(x);
  assign bcd_end  = idx_ext + 17'd2;
  assign spm1     = sp_q - PW'(1);

  // Decode and execute
  logic [2:0]  ex_st;
  logic [15:0] ex_npc, ex_idx;
  logic        ex_we, ex_flag, ex_idx_we, ex_push, ex_pop, ex_clr, ex_wk;
  logic [7:0]  ex_wval, ex_tv, src, kmask_b;
  logic [8:0]  sum9;
  logic [1:0]  ex_tw;
  cls_e        ex_cls;
  logic [15:0] kmask;
  logic [3:0]  kidx;
  logic        kfound, fault;

  always_comb begin
    kmask  = in_q.keys_held ^ {16{cfg_wait_q}};
    kfound = |kmask;
    kidx   = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (kmask[k]) kidx = 4'(k);
    end
  end

  assign src     = cfg_shift_q ? vx_q : vy_q;
  assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
  assign kmask_b = in_q.random_byte & kk;

  always_comb begin
    ex_st     = ST_OK;
    ex_npc    = pc_q + 16'd2;
    ex_we     = 1'b0;
    ex_wval   = 8'h00;
    ex_flag   = 1'b0;
    ex_idx_we = 1'b0;
    ex_idx    = idx_q;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_clr    = 1'b0;
    ex_tw     = TW_NONE;
    ex_tv     = 8'h00;
    ex_wk     = 1'b0;
    ex_cls    = CL_SIMPLE;
    unique case (op_hi)
      OP_SYS: begin
        if (nnn == SYS_CLS) begin
          ex_clr = 1'b1;
        end else if (nnn == SYS_RET) begin
          if (sp_q == '0) begin
            ex_st = ST_UNDER;
          end else begin
            ex_pop = 1'b1;
            ex_npc = stk_rd_q;
          end
        end else begin
          ex_st = ST_BAD_OP;
        end
      end
      OP_JP: ex_npc = {4'h0, nnn};
      OP_CALL: begin
        if (sp_q >= StkFull) begin
          ex_st = ST_OVER;
        end else begin
          ex_push = 1'b1;
          ex_npc  = {4'h0, nnn};
        end
      end
      OP_SE:  if (vx_q == kk) ex_npc = pc_q + 16'd4;
      OP_SNE: if (vx_q != kk) ex_npc = pc_q + 16'd4;
      OP_SER: begin
        if (z != 4'h0)          ex_st  = ST_BAD_OP;
        else if (vx_q == vy_q)  ex_npc = pc_q + 16'd4;
      end
      OP_LD: begin
        ex_we   = 1'b1;
        ex_wval = kk;
      end
      OP_ADD: begin
        ex_we   = 1'b1;
        ex_wval = vx_q + kk;
      end
      OP_ALU: begin
        ex_we = 1'b1;
        unique case (z)
          ALU_MOV: ex_wval = vy_q;
          ALU_OR:  ex_wval = vx_q | vy_q;
          ALU_AND: ex_wval = vx_q & vy_q;
          ALU_XOR: ex_wval = vx_q ^ vy_q;
          ALU_ADD: begin
            ex_wval = sum9[7:0];
            ex_flag = sum9[8];
            ex_cls  = CL_FLAG;
          end
          ALU_SUB: begin
            ex_wval = vx_q - vy_q;
            ex_flag = (vx_q >= vy_q);
            ex_cls  = CL_FLAG;
          end
          ALU_SHR: begin
            ex_wval = {1'b0, src[7:1]};
            ex_flag = src[0];
            ex_cls  = CL_FLAG;
          end
          ALU_SUBN: begin
            ex_wval = vy_q - vx_q;
            ex_flag = (vy_q >= vx_q);
            ex_cls  = CL_FLAG;
          end
          ALU_SHL: begin
            ex_wval = {src[6:0], 1'b0};
            ex_flag = src[7];
            ex_cls  = CL_FLAG;
          end
          default: begin
            ex_we = 1'b0;
            ex_st = ST_BAD_OP;
          end
        endcase
      end
      OP_SNER: begin
        if (z != 4'h0)          ex_st  = ST_BAD_OP;
        else if (vx_q != vy_q)  ex_npc = pc_q + 16'd4;
      end
      OP_LDI: begin
        ex_idx_we = 1'b1;
        ex_idx    = {4'h0, nnn};
      end
      OP_JPV: ex_npc = {4'h0, nnn} + {8'h00, vy_q};
      OP_RND: begin
        ex_we   = 1'b1;
        ex_wval = kmask_b;
      end
      OP_DRW: begin
        if (z != 4'h0 && draw_end >= RamLim) ex_st  = ST_MEM;
        else                                 ex_cls = CL_DRAW;
      end
      OP_KEY: begin
        if (vx_q[7:4] != 4'h0) begin
          ex_st = ST_KEY;
        end else if (kk == KK_SKP) begin
          if (in_q.keys_held[vx_q[3:0]]) ex_npc = pc_q + 16'd4;
        end else if (kk == KK_SKNP) begin
          if (!in_q.keys_held[vx_q[3:0]]) ex_npc = pc_q + 16'd4;
        end else begin
          ex_st = ST_BAD_OP;
        end
      end
      OP_MISC: begin
        unique case (kk)
          KK_LDDT: begin
            ex_we   = 1'b1;
            ex_wval = in_q.delay_value;
          end
          KK_WAIT: begin
            if (kfound) begin
              ex_we   = 1'b1;
              ex_wval = {4'h0, kidx};
            end else begin
              ex_npc = pc_q;
              ex_wk  = 1'b1;
            end
          end
          KK_SETDT: begin
            ex_tw = TW_DELAY;
            ex_tv = vx_q;
          end
          KK_SETST: begin
            ex_tw = TW_SOUND;
            ex_tv = vx_q;
          end
          KK_ADDI: begin
            ex_idx_we = 1'b1;
            ex_idx    = idx_q + {8'h00, vx_q};
          end
          KK_FONT: begin
            ex_idx_we = 1'b1;
            ex_idx    = FontB + {12'h000, vx_q[3:0]} + {10'h000, vx_q[3:0], 2'b00};
          end
          KK_BCD: begin
            if (idx_q < ProgSt || bcd_end >= RamLim) ex_st  = ST_MEM;
            else                                    ex_cls = CL_BCD;
          end
          KK_STORE: begin
            if (blk_end >= RamLim || (x != 4'h0 && idx_q < ProgSt)) ex_st  = ST_MEM;
            else                                                   ex_cls = CL_STORE;
          end
          KK_LOAD: begin
            if (blk_end >= RamLim) ex_st  = ST_MEM;
            else                   ex_cls = CL_LOAD;
          end
          default: ex_st = ST_BAD_OP;
        endcase
      end
    endcase
  end

  assign fault = (ex_st != ST_OK);

  // Step counter end for the active class
  logic [3:0] cnt_end;
  always_comb begin
    unique case (cls_q)
      CL_DRAW: cnt_end = z - 4'd1;
      CL_BCD:  cnt_end = 4'd2;
      default: cnt_end = x;
    endcase
  end

  assign sts_o.kind       = in_q.kind;
  assign sts_o.fault      = fault;
  assign sts_o.cls        = ex_cls;
  assign sts_o.cnt_last   = (cnt_q == cnt_end);
  assign sts_o.row_ok     = (drow_q < ScrH);
  assign sts_o.draw_empty = (z == 4'h0);

  logic ex_commit;
  assign ex_commit = (cmd_i.op == CMD_EXEC) && !fault;

  // Register file ports
  logic [3:0] gp_raddr, gp_waddr;
  logic [7:0] gp_rd, gp_wdata;
  logic       gp_we;
  always_comb begin
    unique case (cmd_i.op)
      CMD_RDY: gp_raddr = (op_hi == OP_JPV) ? 4'h0 : y;
      CMD_BST: gp_raddr = cnt_q;
      default: gp_raddr = x;
    endcase
  end
  assign gp_rd = gp_q[gp_raddr];

  always_comb begin
    gp_we    = 1'b0;
    gp_waddr = x;
    gp_wdata = ex_wval;
    unique case (cmd_i.op)
      CMD_EXEC: gp_we = ex_commit && ex_we;
      CMD_FLAG: begin
        gp_we    = 1'b1;
        gp_waddr = 4'hF;
        gp_wdata = {7'h00, flag_q};
      end
      CMD_DVF: begin
        gp_we    = 1'b1;
        gp_waddr = 4'hF;
        gp_wdata = {7'h00, coll_q};
      end
      CMD_BLDW: begin
        gp_we    = 1'b1;
        gp_waddr = cnt_q;
        gp_wdata = mem_rd_q;
      end
      default: gp_we = 1'b0;
    endcase
  end

  // Main memory write port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_in_range;
  assign mem_in_range = ({5'h00, in_q.address} < RamLim);
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk_addr[AW-1:0];
    mem_wdata = gp_rd;
    unique case (cmd_i.op)
      CMD_MEMWR: begin
        mem_we    = mem_in_range;
        mem_waddr = AW'({5'h00, in_q.address});
        mem_wdata = in_q.data;
      end
      CMD_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx_q, cnt_q[1:0]);
      end
      CMD_BST: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.op == CMD_DRD || cmd_i.op == CMD_BLDR) mem_rd_q <= mem_q[blk_addr[AW-1:0]];
  end

  // Display memory
  logic [HW-1:0] disp_raddr;
  logic [63:0]   spr_lin, spr_rot, old_row, new_row;
  logic [127:0]  spr_dbl;
  always_comb begin
    spr_lin = '0;
    for (int c = 0; c < 8; c++) spr_lin[c] = mem_rd_q[7-c];
  end
  assign spr_dbl    = {spr_lin, spr_lin} << vx_q[5:0];
  assign spr_rot    = spr_dbl[127:64];
  assign old_row    = disp_vld_rd_q ? disp_rd_q : 64'h0;
  assign new_row    = old_row ^ spr_rot;
  assign disp_raddr = (cmd_i.op == CMD_ROWRD) ? in_q.address[HW-1:0] : drow_q[HW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_DWR) disp_mem[drow_q[HW-1:0]] <= new_row;
    if (cmd_i.op == CMD_DRD || cmd_i.op == CMD_ROWRD) begin
      disp_rd_q     <= disp_mem[disp_raddr];
      disp_vld_rd_q <= disp_vld_q[disp_raddr];
    end
  end

  // Return stack
  always_ff @(posedge clk_i) begin
    if (ex_commit && ex_push) stk_mem[sp_q[SW-1:0]] <= pc_q + 16'd2;
    if (cmd_i.op == CMD_RDX)  stk_rd_q <= stk_mem[spm1[SW-1:0]];
  end

  // Block end index advance
  logic blk_done;
  assign blk_done = (cmd_i.op == CMD_BST || cmd_i.op == CMD_BLDW) && (cnt_q == cnt_end)
                    && !cfg_keep_q;

  // Architectural registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 16; r++) gp_q[r] <= 8'h00;
      pc_q        <= ProgSt;
      idx_q       <= 16'h0000;
      sp_q        <= '0;
      disp_vld_q  <= '0;
      cfg_shift_q <= 1'b0;
      cfg_keep_q  <= 1'b0;
      cfg_wait_q  <= 1'b0;
    end else begin
      if (gp_we) gp_q[gp_waddr] <= gp_wdata;
      if (ex_commit) begin
        pc_q <= ex_npc;
        if (ex_idx_we) idx_q <= ex_idx;
        if (ex_push)   sp_q  <= sp_q + PW'(1);
        if (ex_pop)    sp_q  <= spm1;
        if (ex_clr)    disp_vld_q <= '0;
      end
      if (blk_done) idx_q <= idx_q + {12'h000, x} + 16'd1;
      if (cmd_i.op == CMD_DWR) disp_vld_q[drow_q[HW-1:0]] <= 1'b1;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SHIFT_VX: cfg_shift_q <= cfg_data_i;
          CFG_KEEP_IDX: cfg_keep_q  <= cfg_data_i;
          CFG_WAIT_REL: cfg_wait_q  <= cfg_data_i;
          default:      cfg_wait_q  <= cfg_wait_q;
        endcase
      end
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LATCH: begin
        in_q <= in_req_i;
        st_q <= ST_OK;
        tw_q <= TW_NONE;
        tv_q <= 8'h00;
        wk_q <= 1'b0;
        row_q <= 64'h0;
      end
      CMD_RDX: vx_q <= gp_rd;
      CMD_RDY: vy_q <= gp_rd;
      CMD_EXEC: begin
        st_q   <= ex_st;
        cls_q  <= ex_cls;
        flag_q <= ex_flag;
        cnt_q  <= 4'd0;
        coll_q <= 1'b0;
        drow_q <= vy_q;
        if (!fault) begin
          tw_q <= ex_tw;
          tv_q <= ex_tv;
          wk_q <= ex_wk;
        end
      end
      CMD_DMOD: if (drow_q >= ScrH) drow_q <= drow_q - ScrH;
      CMD_DWR: begin
        coll_q <= coll_q | (|(old_row & spr_rot));
        cnt_q  <= cnt_q + 4'd1;
        drow_q <= (drow_q == ScrH - 8'd1) ? 8'd0 : drow_q + 8'd1;
      end
      CMD_BCD, CMD_BST, CMD_BLDW: cnt_q <= cnt_q + 4'd1;
      CMD_MEMWR: if (!mem_in_range) st_q <= ST_MEM;
      CMD_ROWRD: row_ok_q <= (in_q.address < ScrHA);
      CMD_ROWCAP: row_q <= (row_ok_q && disp_vld_rd_q) ? disp_rd_q : 64'h0;
      CMD_RESULT: begin
        out_q.status      <= st_q;
        out_q.next_pc     <= pc_q;
        out_q.timer_write <= tw_q;
        out_q.timer_value <= tv_q;
        out_q.display_row <= row_q;
        out_q.waiting_key <= wk_q;
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  assign out_rsp_o = out_q;

endmodule

// File: hdl/c8x_chk.sv
// ----------------------------------------------------------------------------
// c8x_chk
// Port-level checks of the instruction execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "chip8_instruction_execute_top_defines.svh"

module c8x_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input c8x_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input c8x_pkg::out_rsp_t out_rsp_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [1:0]        cfg_index_i,
  input logic              cfg_data_i
);
  import c8x_pkg::*;

  // Hold a stalled result
  `C8X_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "result changed while stalled")

  // Drop ready right after taking a request
  `C8X_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

  // Faults carry no side results
  `C8X_ASSERT_NOW(a_fault_clean, out_valid_o && (out_rsp_o.status != ST_OK), (out_rsp_o.timer_write == TW_NONE) && !out_rsp_o.waiting_key && (out_rsp_o.display_row == 64'h0), "fault result carries side fields")

  // Key wait reports success and no timer write
  `C8X_ASSERT_NOW(a_wait_clean, out_valid_o && out_rsp_o.waiting_key, (out_rsp_o.status == ST_OK) && (out_rsp_o.timer_write == TW_NONE), "key wait result inconsistent")

endmodule

bind chip8_instruction_execute_top c8x_chk u_chk (.*);
